FILE: design/piecewise_linear_eval_defines.svh
// Assertion macros for the piecewise linear evaluator.
`ifndef PIECEWISE_LINEAR_EVAL_DEFINES_SVH
`define PIECEWISE_LINEAR_EVAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define PLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define PLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PLE_ASSERT(name, prop, msg)
`define PLE_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: design/ple_pkg.sv
package ple_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 136;

  // input tdata layout
  localparam int unsigned OFS_INDEX = 0;
  localparam int unsigned OFS_RIGHT = OFS_INDEX + INDEX_W;
  localparam int unsigned OFS_SLOPE = OFS_RIGHT + DATA_W;
  localparam int unsigned OFS_ICPT  = OFS_SLOPE + DATA_W;
  localparam int unsigned OFS_X     = OFS_ICPT + DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT   = 2'd2;

  localparam logic KIND_LOAD = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_OUTSIDE,
    STATUS_NO_SEG,
    STATUS_SAT
  } ple_status_e;

  typedef struct packed {
    logic take_in;
    logic step;
    logic mul;
    logic sum;
    logic out_load;
  } ple_cmd_t;

  typedef struct packed {
    logic early;
    logic search_done;
    logic found;
  } ple_stat_t;

endpackage

FILE: design/ple_datapath.sv
`include "piecewise_linear_eval_defines.svh"

module ple_datapath
  import ple_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 in_kind_i,
  input  ple_cmd_t             cmd_i,
  output ple_stat_t            stat_o,
  output logic [DATA_W-1:0]    out_value_o,
  output ple_status_e          out_status_o
);

  localparam int unsigned AW     = $clog2(MAX_SEGMENTS);
  localparam int unsigned LW     = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CW     = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int unsigned IW     = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int unsigned ROW_W  = 3 * DATA_W;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam logic [PROD_W-1:0] ROUND_ADD = (PROD_W'(1) << FRAC_BITS) >> 1;

  logic signed [DATA_W-1:0] domain_low_q, domain_high_q;
  logic [COUNT_W-1:0]       seg_count_q;

  logic [ROW_W-1:0]         seg_mem [MAX_SEGMENTS];
  logic [ROW_W-1:0]         rd_row_q;

  logic signed [DATA_W-1:0] x_q;
  logic [LW-1:0]            lo_q, len_q, n_q;
  logic signed [PROD_W-1:0] prod_q, addend_q;
  logic [DATA_W-1:0]        res_value_q, out_value_q;
  ple_status_e              res_status_q, out_status_q;

  logic signed [DATA_W-1:0] x_in;
  logic [INDEX_W-1:0]       seg_index;
  logic [IW-1:0]            idx_ext;
  logic                     idx_ok, is_load, outside, n_zero, mem_we, rd_en;
  logic [CW-1:0]            count_ext;
  logic [LW-1:0]            n_in, half, mid, lo_n, len_n, rd_addr_full;
  logic [AW-1:0]            rd_addr;
  logic                     right_le;
  logic signed [DATA_W-1:0] rd_right, rd_slope, rd_icpt;
  logic signed [PROD_W-1:0] sum_full, shifted;
  logic                     sat_hi, sat_lo;
  logic [LW:0]              span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_low_q  <= '0;
      domain_high_q <= '0;
      seg_count_q   <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DOMAIN_LOW:  domain_low_q  <= cfg_data_i;
        CFG_DOMAIN_HIGH: domain_high_q <= cfg_data_i;
        CFG_SEG_COUNT:   seg_count_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign x_in      = $signed(in_data_i[OFS_X +: DATA_W]);
  assign seg_index = in_data_i[OFS_INDEX +: INDEX_W];
  assign idx_ext   = IW'(seg_index);
  assign idx_ok    = 32'(seg_index) < MAX_SEGMENTS;
  assign is_load   = in_kind_i == KIND_LOAD;
  assign outside   = (x_in > domain_high_q) || (x_in < domain_low_q);

  assign count_ext = CW'(seg_count_q);
  assign n_in      = (count_ext > CW'(MAX_SEGMENTS)) ? LW'(MAX_SEGMENTS) : LW'(count_ext);
  assign n_zero    = n_in == '0;

  assign rd_right = $signed(rd_row_q[0 +: DATA_W]);
  assign rd_slope = $signed(rd_row_q[DATA_W +: DATA_W]);
  assign rd_icpt  = $signed(rd_row_q[2*DATA_W +: DATA_W]);

  // one halving step of the lower-bound search
  always_comb begin
    half     = len_q >> 1;
    mid      = lo_q + half;
    right_le = rd_right <= x_q;
    if (right_le) begin
      lo_n  = mid + LW'(1);
      len_n = len_q - half - LW'(1);
    end else begin
      lo_n  = lo_q;
      len_n = half;
    end
  end

  assign rd_addr_full = cmd_i.take_in ? (n_in >> 1) : (lo_n + (len_n >> 1));
  assign rd_addr      = rd_addr_full[AW-1:0];
  assign rd_en        = cmd_i.take_in | cmd_i.step;
  assign mem_we       = cmd_i.take_in & is_load & idx_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[idx_ext[AW-1:0]] <= in_data_i[OFS_RIGHT +: ROW_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= seg_mem[rd_addr];
    end
  end

  assign stat_o.early       = is_load | outside | n_zero;
  assign stat_o.search_done = len_n == '0;
  assign stat_o.found       = lo_n < n_q;

  // rounding and intercept folded into one addend: (p + c*2^F + 2^(F-1)) >>> F
  assign sum_full = prod_q + addend_q;
  assign shifted  = sum_full >>> FRAC_BITS;
  assign sat_hi   = !shifted[PROD_W-1] && (|shifted[PROD_W-2:DATA_W-1]);
  assign sat_lo   = shifted[PROD_W-1] && !(&shifted[PROD_W-2:DATA_W-1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      x_q         <= x_in;
      lo_q        <= '0;
      len_q       <= n_in;
      n_q         <= n_in;
      res_value_q <= '0;
      if (is_load) begin
        res_status_q <= STATUS_OK;
      end else if (outside) begin
        res_status_q <= STATUS_OUTSIDE;
      end else if (n_zero) begin
        res_status_q <= STATUS_NO_SEG;
      end else begin
        res_status_q <= STATUS_OK;
      end
    end
    if (cmd_i.step) begin
      lo_q  <= lo_n;
      len_q <= len_n;
      if (len_n == '0 && !(lo_n < n_q)) begin
        res_status_q <= STATUS_NO_SEG;
      end
    end
    if (cmd_i.mul) begin
      prod_q   <= PROD_W'(rd_slope) * PROD_W'(x_q);
      addend_q <= ({{DATA_W{rd_icpt[DATA_W-1]}}, rd_icpt} <<< FRAC_BITS) | ROUND_ADD;
    end
    if (cmd_i.sum) begin
      if (sat_hi) begin
        res_value_q  <= {1'b0, {(DATA_W-1){1'b1}}};
        res_status_q <= STATUS_SAT;
      end else if (sat_lo) begin
        res_value_q  <= {1'b1, {(DATA_W-1){1'b0}}};
        res_status_q <= STATUS_SAT;
      end else begin
        res_value_q  <= shifted[DATA_W-1:0];
        res_status_q <= STATUS_OK;
      end
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  assign span = (LW+1)'(lo_q) + (LW+1)'(len_q);

  `PLE_ASSERT(a_step_nonempty, cmd_i.step |-> len_q != '0, "search step on empty range")
  `PLE_ASSERT(a_step_in_range, cmd_i.step |-> span <= (LW+1)'(n_q), "search range past count")

endmodule

FILE: design/ple_ctrl.sv
`include "piecewise_linear_eval_defines.svh"

module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ple_stat_t stat_i,
  output ple_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.take_in = 1'b1;
          state_d       = stat_i.early ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (stat_i.search_done) begin
          state_d = stat_i.found ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= state_d == ST_IDLE;
      out_valid_q <= cmd_o.out_load | (out_valid_q & ~out_ready_i);
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `PLE_ASSERT(a_ready_idle, in_ready_q == (state_q == ST_IDLE), "ready out of step with state")
  `PLE_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command")
  `PLE_ASSERT(a_no_overwrite, cmd_o.out_load |-> !out_valid_q || out_ready_i, "result overwritten")

endmodule

FILE: design/piecewise_linear_eval.sv
// channel  | signals          | payload, lowest bit first
// ---------+------------------+--------------------------------------------------
// input    | s_axis_t*        | tuser: kind; tdata: seg_index, seg_right,
//          |                  |   seg_slope, seg_intercept, query_x, 2 pad bits
// output   | m_axis_t*        | tdata: value; tuser: status
// config   | cfg_we_i etc.    | index 0 domain_low, 1 domain_high, 2 segment_count
//
// One item at a time. A load, an out-of-domain query or an empty search range
// goes straight to the result. An evaluate runs s <= ceil(log2(n+1))
// search steps over n segments, one table read each; with no segment found it ends
// there, else a multiply step and an add-and-clamp step follow. The next transfer
// is taken the cycle after the result is registered; a stalled result holds back
// the next one. Reset clears control state and domain, sets count 1, not the table.
module piecewise_linear_eval
  import ple_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // seg_index, seg_right, seg_slope, seg_intercept, query_x, zero pad
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // kind
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // value
  output logic [DATA_W-1:0]    m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]  m_axis_tuser
);

  ple_cmd_t    cmd;
  ple_stat_t   stat;
  ple_status_e out_status;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ple_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_value_o  (m_axis_tdata),
    .out_status_o (out_status)
  );

  assign m_axis_tuser = out_status;

endmodule
